// ===== hdl/rbs_pkg.sv =====
package rbs_pkg;

  localparam int MAX_RECORDS_DEF = 8;
  localparam int KEY_W = 32;
  localparam int PAY_W = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic        [PAY_W-1:0] sorted_payload;
    logic                    end_of_set;
  } out_word_t;

  // one record as held in a cell of the chain
  typedef struct packed {
    logic                    vld;
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] pay;
  } slot_t;

  // chain-wide control, the same for every cell
  typedef struct packed {
    logic ins;  // insert the incoming record this cycle
    logic shf;  // shift the chain toward cell 0
  } ctl_t;

endpackage

// ===== hdl/record_bubble_sort.sv =====
// Sorts a set of up to MAX_RECORDS records (signed 32-bit key, 16-bit payload)
// and returns them lowest key first; records with equal keys leave in arrival
// order. Input words are taken one per cycle: each record is placed into its
// sorted position in a row of MAX_RECORDS cells as it arrives, so no sort pass
// follows the set. The word flagged last closes the set; from the next cycle
// cell 0 presents the smallest record and each taken output word shifts the
// row by one cell, with end_of_set on the final word. No input is taken while
// a set drains. Records that arrive while all cells are full are dropped, but
// a dropped word flagged last still closes the set.
module record_bubble_sort #(
  parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rbs_pkg::out_word_t out_data
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  rbs_pkg::slot_t slots [MAX_RECORDS];
  logic           gts   [MAX_RECORDS];
  rbs_pkg::slot_t new_slot;
  rbs_pkg::ctl_t  ctl;
  logic           in_acc;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;

  assign new_slot.vld = 1'b1;
  assign new_slot.key = in_data.key;
  assign new_slot.pay = in_data.payload;

  // drop the record when the last cell is already taken
  assign ctl.ins = in_acc && !slots[MAX_RECORDS-1].vld;
  assign ctl.shf = out_valid && out_ready;

  genvar i;
  generate
    for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
      rbs_pkg::slot_t left_slot;
      rbs_pkg::slot_t right_slot;
      logic           left_gt;

      if (i == 0) begin : g_first
        assign left_slot = '0;
        assign left_gt   = 1'b0;
      end else begin : g_mid
        assign left_slot = slots[i-1];
        assign left_gt   = gts[i-1];
      end

      if (i == MAX_RECORDS - 1) begin : g_tail
        assign right_slot = '0;
      end else begin : g_body
        assign right_slot = slots[i+1];
      end

      rbs_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_slot   (new_slot),
        .left_slot  (left_slot),
        .left_gt    (left_gt),
        .right_slot (right_slot),
        .slot       (slots[i]),
        .gt         (gts[i])
      );
    end
  endgenerate

  assign out_valid               = (state_r == ST_DRAIN) && slots[0].vld;
  assign out_data.sorted_key     = slots[0].key;
  assign out_data.sorted_payload = slots[0].pay;
  assign out_data.end_of_set     = !slots[1].vld;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // leave once the final word is taken
        if (ctl.shf && !slots[1].vld) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/rbs_cell.sv =====
module rbs_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  rbs_pkg::ctl_t  ctl,
  input  rbs_pkg::slot_t new_slot,
  input  rbs_pkg::slot_t left_slot,
  input  logic           left_gt,
  input  rbs_pkg::slot_t right_slot,
  output rbs_pkg::slot_t slot,
  output logic           gt
);

  rbs_pkg::slot_t slot_r;
  rbs_pkg::slot_t slot_nxt;

  // empty cells count as greater, so the free tail always opens up
  assign gt   = !slot_r.vld || (slot_r.key > new_slot.key);
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.ins) begin
      if (left_gt) begin
        slot_nxt = left_slot;
      end else if (gt) begin
        slot_nxt     = new_slot;
        slot_nxt.vld = 1'b1;
      end
    end else if (ctl.shf) begin
      slot_nxt = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else begin
      slot_r.vld <= slot_nxt.vld;
    end
    slot_r.key <= slot_nxt.key;
    slot_r.pay <= slot_nxt.pay;
  end

endmodule
